FILE: rtl/sbic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbic_pkg
// Shared types and constants for the skin bone index compactor: the input
// and result item layouts and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbic_pkg;

    // Default sizes of the bone store, the dense ID space and the slot count.
    localparam int DEF_TOTAL_BONE_SLOTS = 256;
    localparam int DEF_MAX_DENSE_IDS    = 64;
    localparam int DEF_MAX_INFLUENCES   = 4;

    // Number of influence slot fields carried by one item.
    localparam int SLOT_FIELDS = 4;
    localparam int SLOT_W      = 2;
    localparam int CFG_W       = 3;

    // Reset value of the slot count register.
    localparam logic [CFG_W-1:0] CFG_RESET = 3'd4;

    // One vertex: clear request, four raw bone indices and four weights.
    typedef struct packed {
        logic        clear_table;
        logic [7:0]  bone_index_0;
        logic [7:0]  bone_index_1;
        logic [7:0]  bone_index_2;
        logic [7:0]  bone_index_3;
        logic [15:0] weight_0;
        logic [15:0] weight_1;
        logic [15:0] weight_2;
        logic [15:0] weight_3;
    } t_in_item;

    // One result item per vertex.
    typedef struct packed {
        logic [7:0] primary_bone;
        logic [7:0] dense_id_1;
        logic [7:0] dense_id_2;
        logic [7:0] dense_id_3;
        logic [3:0] new_mask;
        logic [7:0] ids_used;
        logic       overflow;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              resolve;
        logic              emit;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stopped;
    } t_status;

endpackage : sbic_pkg
`default_nettype wire

FILE: rtl/sbic_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbic_ctrl
// Controller: holds the slot count register, accepts items and steps the
// datapath through the examined slots one per cycle, then issues the result.
// ----------------------------------------------------------------------------
module sbic_ctrl #(
    parameter int MAX_INFLUENCES = sbic_pkg::DEF_MAX_INFLUENCES
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [sbic_pkg::CFG_W-1:0] i_cfg_data,
    input  wire sbic_pkg::t_status         i_status,
    output sbic_pkg::t_cmd                 o_cmd
);
    import sbic_pkg::*;

    localparam int SLOT_CAP = (MAX_INFLUENCES < SLOT_FIELDS) ? MAX_INFLUENCES : SLOT_FIELDS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CFG_W-1:0]  r_cfg;
    logic [CFG_W-1:0]  slots_used;
    logic [SLOT_W-1:0] last_slot;

    // The register is only taken between items, so the slot count stays
    // fixed while an item is being worked on.
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);

    // Slot count with zero taken as one and clipped to the slot capacity.
    always_comb begin
        slots_used = (r_cfg == '0) ? CFG_W'(1) : r_cfg;
        if (slots_used > CFG_W'(SLOT_CAP)) begin
            slots_used = CFG_W'(SLOT_CAP);
        end
        last_slot = SLOT_W'(slots_used - CFG_W'(1));
    end

    // Sequencer: one slot resolved per cycle, then the result is formed in the emit state.
    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        o_cmd         = '0;
        o_cmd.slot    = r_slot;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_slot     = '0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.resolve = 1'b1;
                if (r_slot == last_slot || i_status.stopped) begin
                    n_state = ST_EMIT;
                end else begin
                    n_slot = r_slot + SLOT_W'(1);
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_cfg   <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

endmodule : sbic_ctrl
`default_nettype wire

FILE: rtl/sbic_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbic_datapath
// Datapath: the bone to dense ID store with per-entry valid bits, the ID
// counter, the sticky error and the per-item slot and primary registers.
// ----------------------------------------------------------------------------
module sbic_datapath #(
    parameter int TOTAL_BONE_SLOTS = sbic_pkg::DEF_TOTAL_BONE_SLOTS,
    parameter int MAX_DENSE_IDS    = sbic_pkg::DEF_MAX_DENSE_IDS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sbic_pkg::t_in_item i_item,
    input  wire sbic_pkg::t_cmd     i_cmd,
    output sbic_pkg::t_status       o_status,
    output sbic_pkg::t_out_item     o_result,
    output logic                    o_result_valid
);
    import sbic_pkg::*;

    // Raw indices are 8 bits wide, so at most 256 entries can be reached.
    localparam int MAP_DEPTH = (TOTAL_BONE_SLOTS < 256) ? TOTAL_BONE_SLOTS : 256;
    localparam int AW        = $clog2(MAP_DEPTH);

    // Store of dense IDs, read in the cycle before the slot that uses the entry is resolved.
    logic [7:0] mem [MAP_DEPTH];
    logic [7:0] r_mem_q;

    logic [MAP_DEPTH-1:0] r_valid, n_valid;
    logic [7:0]           r_count, n_count;
    logic                 r_err, n_err;
    logic                 r_stopped, n_stopped;
    logic                 r_result_valid;

    logic [7:0]  r_idx [SLOT_FIELDS];
    logic [7:0]  n_idx [SLOT_FIELDS];
    logic [15:0] r_w [SLOT_FIELDS];
    logic [3:0]  r_mask, n_mask;
    logic [15:0] r_best_w, n_best_w;
    logic        r_best_any, n_best_any;
    logic [7:0]  r_primary, n_primary;
    logic        r_fwd_hit;
    logic [7:0]  r_fwd_data;
    t_out_item   r_result, n_result;

    logic [7:0]        bone;
    logic [15:0]       wt;
    logic [AW-1:0]     baddr;
    logic [AW-1:0]     rd_addr;
    logic [SLOT_W-1:0] next_slot;
    logic [7:0]        entry;
    logic [7:0]        new_idx;
    logic              active;
    logic              wr_en;
    logic              take;

    assign o_status.stopped = r_stopped;
    assign o_result         = r_result;
    assign o_result_valid   = r_result_valid;

    // Slot resolve: look up, assign a fresh ID if needed, track the primary.
    always_comb begin
        n_valid    = r_valid;
        n_count    = r_count;
        n_err      = r_err;
        n_stopped  = r_stopped;
        n_idx      = r_idx;
        n_mask     = r_mask;
        n_best_w   = r_best_w;
        n_best_any = r_best_any;
        n_primary  = r_primary;
        n_result   = r_result;
        wr_en      = 1'b0;
        take       = 1'b0;
        new_idx    = '0;

        bone      = r_idx[i_cmd.slot];
        baddr     = bone[AW-1:0];
        wt        = (int'(bone) < TOTAL_BONE_SLOTS) ? r_w[i_cmd.slot] : '0;
        entry     = r_fwd_hit ? r_fwd_data : r_mem_q;
        active    = i_cmd.resolve && !r_stopped;
        next_slot = i_cmd.slot + SLOT_W'(1);
        rd_addr   = i_cmd.load ? i_item.bone_index_0[AW-1:0] : r_idx[next_slot][AW-1:0];

        if (i_cmd.load) begin
            // A new model clears the store, the counter and the error at once.
            if (i_item.clear_table) begin
                n_valid = '0;
                n_count = '0;
                n_err   = 1'b0;
            end
            n_stopped  = i_item.clear_table ? 1'b0 : r_err;
            n_idx[0]   = i_item.bone_index_0;
            n_idx[1]   = i_item.bone_index_1;
            n_idx[2]   = i_item.bone_index_2;
            n_idx[3]   = i_item.bone_index_3;
            n_mask     = '0;
            n_best_w   = '0;
            n_best_any = 1'b0;
            n_primary  = '0;
        end else if (active) begin
            take    = 1'b1;
            new_idx = bone;
            if (wt != '0) begin
                if (r_valid[baddr]) begin
                    new_idx = entry;
                end else if (r_count >= 8'(MAX_DENSE_IDS)) begin
                    // Out of dense IDs: the item stops here.
                    n_err     = 1'b1;
                    n_stopped = 1'b1;
                    take      = 1'b0;
                end else begin
                    wr_en                = 1'b1;
                    new_idx              = r_count;
                    n_valid[baddr]       = 1'b1;
                    n_count              = r_count + 8'd1;
                    n_mask[i_cmd.slot]   = 1'b1;
                end
            end
            if (take) begin
                n_idx[i_cmd.slot] = new_idx;
                if (!r_best_any || wt > r_best_w) begin
                    n_best_w   = wt;
                    n_best_any = 1'b1;
                    n_primary  = new_idx;
                end
            end
        end

        // Result item, formed once all slots are done or the item has stopped.
        if (i_cmd.emit) begin
            n_result.primary_bone = r_stopped ? 8'd0 : r_primary;
            n_result.dense_id_1   = r_stopped ? 8'd0 : r_idx[1];
            n_result.dense_id_2   = r_stopped ? 8'd0 : r_idx[2];
            n_result.dense_id_3   = r_stopped ? 8'd0 : r_idx[3];
            n_result.new_mask     = r_mask;
            n_result.ids_used     = r_count;
            n_result.overflow     = r_err;
        end
    end

    // Store write and registered read, with a bypass for a read issued in
    // the cycle that writes the same entry.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[baddr] <= r_count;
        end
        r_mem_q    <= mem[rd_addr];
        r_fwd_hit  <= wr_en && (baddr == rd_addr);
        r_fwd_data <= r_count;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= '0;
            r_count        <= '0;
            r_err          <= 1'b0;
            r_stopped      <= 1'b0;
            r_result_valid <= 1'b0;
        end else begin
            r_valid        <= n_valid;
            r_count        <= n_count;
            r_err          <= n_err;
            r_stopped      <= n_stopped;
            r_result_valid <= i_cmd.emit;
        end
    end

    // Per-item payload registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_mask     <= n_mask;
        r_best_w   <= n_best_w;
        r_best_any <= n_best_any;
        r_primary  <= n_primary;
        r_result   <= n_result;
        if (i_cmd.load) begin
            r_w[0] <= i_item.weight_0;
            r_w[1] <= i_item.weight_1;
            r_w[2] <= i_item.weight_2;
            r_w[3] <= i_item.weight_3;
        end
    end

endmodule : sbic_datapath
`default_nettype wire

FILE: rtl/skin_bone_index_compactor.sv
`default_nettype none
// Flow: an item is accepted, its examined slots (1 to 4) are resolved in
// turn through the registered read of the bone store, and the result is then
// formed and strobed. A new item is taken only once that result is formed;
// an item that stops on error skips its remaining slots.
// Reset clears the store at once through per-entry valid bits; the receiver
// cannot stall the result strobe.
// ----------------------------------------------------------------------------
// skin_bone_index_compactor
// Compacts the raw bone indices of skinned vertices into dense IDs and picks
// the primary bone of each vertex.
// ----------------------------------------------------------------------------
module skin_bone_index_compactor #(
    parameter int TOTAL_BONE_SLOTS = sbic_pkg::DEF_TOTAL_BONE_SLOTS,
    parameter int MAX_DENSE_IDS    = sbic_pkg::DEF_MAX_DENSE_IDS,
    parameter int MAX_INFLUENCES   = sbic_pkg::DEF_MAX_INFLUENCES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire sbic_pkg::t_in_item         i_item,
    output sbic_pkg::t_out_item             o_result,
    output logic                            o_result_valid,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [sbic_pkg::CFG_W-1:0] i_cfg_data
);
    import sbic_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequencer and slot count register.
    sbic_ctrl #(
        .MAX_INFLUENCES (MAX_INFLUENCES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Store, counter and per-item registers.
    sbic_datapath #(
        .TOTAL_BONE_SLOTS (TOTAL_BONE_SLOTS),
        .MAX_DENSE_IDS    (MAX_DENSE_IDS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

endmodule : skin_bone_index_compactor
`default_nettype wire

FILE: sim/tb_skin_bone_index_compactor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_skin_bone_index_compactor
// Self-checking bench for the bone index compactor. A directed list of
// vertices covers the weight and index extremes, ties, repeated bones, slot
// counts of zero to four and seven, running out of dense IDs, the sticky
// error and its clearing. A random phase follows: vertices drawn from a
// small bone pool mixed with fresh bones, with occasional clears and slot
// count changes. Each result is checked against a written-out expectation
// or a bit-accurate predictor that keeps its own copy of the bone store.
// ----------------------------------------------------------------------------
module tb_skin_bone_index_compactor;

    import sbic_pkg::*;

    localparam int          CLK_HALF       = 4;
    localparam int          RESET_CYCLES   = 7;
    localparam int          RANDOM_ITEMS   = 800;
    localparam int          CFG_EVERY      = 100;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          DENSE_ID_LIMIT = DEF_MAX_DENSE_IDS;
    localparam int          SLOT_CAP       = (DEF_MAX_INFLUENCES < SLOT_FIELDS) ?
                                             DEF_MAX_INFLUENCES : SLOT_FIELDS;
    localparam logic [7:0]  UNASSIGNED_ID  = 8'hFF;
    localparam logic [15:0] WEIGHT_FULL    = 16'hFFFF;

    // One line of the directed stimulus.
    typedef struct {
        logic             cfg_write;
        logic [CFG_W-1:0] cfg_value;
        t_in_item         stim;
        logic             typed;
        t_out_item        result;
    } t_vertex_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    t_in_item         i_item;
    t_out_item        o_result;
    logic             o_result_valid;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    // Predictor state.
    logic [7:0]       bone_id_store [DEF_TOTAL_BONE_SLOTS];
    logic [7:0]       ids_assigned;
    logic             id_overflow;
    logic [CFG_W-1:0] slot_count_cfg;

    t_out_item        pending_results [$];
    t_out_item        oldest_result;
    t_vertex_row      directed_rows [$];
    int               mismatches = 0;
    int               cycle_count = 0;

    skin_bone_index_compactor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result       (o_result),
        .o_result_valid (o_result_valid),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Marks every raw bone as unassigned and forgets any error.
    function automatic void clear_bone_store();
        foreach (bone_id_store[b]) begin
            bone_id_store[b] = UNASSIGNED_ID;
        end
        ids_assigned = '0;
        id_overflow  = 1'b0;
    endfunction

    // Remaps one vertex and advances the predictor state.
    function automatic t_out_item compact_vertex(input t_in_item v);
        logic [7:0]  idx [SLOT_FIELDS];
        logic [15:0] wt [SLOT_FIELDS];
        int          n;
        int          best_weight;
        logic [7:0]  primary;
        logic [3:0]  mask;
        logic        stopped;
        t_out_item   r;
        if (v.clear_table) begin
            clear_bone_store();
        end
        idx = '{v.bone_index_0, v.bone_index_1, v.bone_index_2, v.bone_index_3};
        wt  = '{v.weight_0, v.weight_1, v.weight_2, v.weight_3};
        n = int'(slot_count_cfg);
        if (n == 0) n = 1;
        if (n > SLOT_CAP) n = SLOT_CAP;
        best_weight = -1;
        primary     = '0;
        mask        = '0;
        stopped     = id_overflow;
        for (int i = 0; i < n && !stopped; i++) begin
            if (wt[i] != 0 && bone_id_store[idx[i]] == UNASSIGNED_ID &&
                int'(ids_assigned) >= DENSE_ID_LIMIT) begin
                // Out of dense IDs: the item stops here.
                id_overflow = 1'b1;
                stopped     = 1'b1;
            end else begin
                if (wt[i] != 0) begin
                    if (bone_id_store[idx[i]] == UNASSIGNED_ID) begin
                        bone_id_store[idx[i]] = ids_assigned;
                        ids_assigned          = ids_assigned + 8'd1;
                        mask[i]               = 1'b1;
                    end
                    idx[i] = bone_id_store[idx[i]];
                end
                // Strictly greater, so the first slot wins a tie.
                if (int'(wt[i]) > best_weight) begin
                    best_weight = int'(wt[i]);
                    primary     = idx[i];
                end
            end
        end
        if (stopped) begin
            r.primary_bone = '0;
            r.dense_id_1   = '0;
            r.dense_id_2   = '0;
            r.dense_id_3   = '0;
        end else begin
            r.primary_bone = primary;
            r.dense_id_1   = idx[1];
            r.dense_id_2   = idx[2];
            r.dense_id_3   = idx[3];
        end
        r.new_mask = mask;
        r.ids_used = ids_assigned;
        r.overflow = id_overflow;
        return r;
    endfunction

    function automatic t_in_item make_vertex(
        input logic clr,
        input logic [7:0] b0, input logic [7:0] b1,
        input logic [7:0] b2, input logic [7:0] b3,
        input logic [15:0] w0, input logic [15:0] w1,
        input logic [15:0] w2, input logic [15:0] w3
    );
        t_in_item v;
        v.clear_table  = clr;
        v.bone_index_0 = b0;
        v.bone_index_1 = b1;
        v.bone_index_2 = b2;
        v.bone_index_3 = b3;
        v.weight_0     = w0;
        v.weight_1     = w1;
        v.weight_2     = w2;
        v.weight_3     = w3;
        return v;
    endfunction

    function automatic t_out_item make_result(
        input logic [7:0] p, input logic [7:0] d1, input logic [7:0] d2,
        input logic [7:0] d3, input logic [3:0] m, input logic [7:0] used,
        input logic ovf
    );
        t_out_item r;
        r.primary_bone = p;
        r.dense_id_1   = d1;
        r.dense_id_2   = d2;
        r.dense_id_3   = d3;
        r.new_mask     = m;
        r.ids_used     = used;
        r.overflow     = ovf;
        return r;
    endfunction

    function automatic void add_row(
        input logic cfg_write, input logic [CFG_W-1:0] cfg_value,
        input t_in_item stim, input logic typed, input t_out_item result
    );
        t_vertex_row row;
        row.cfg_write = cfg_write;
        row.cfg_value = cfg_value;
        row.stim      = stim;
        row.typed     = typed;
        row.result    = result;
        directed_rows.push_back(row);
    endfunction

    // A random vertex: bones mostly from a small pool so that IDs repeat,
    // weights biased towards zero, the extremes and a shared tie value.
    function automatic t_in_item random_vertex();
        t_in_item    v;
        logic [7:0]  bones [SLOT_FIELDS];
        logic [15:0] wts [SLOT_FIELDS];
        logic [15:0] tie_weight;
        tie_weight = 16'($urandom);
        foreach (bones[s]) begin
            bones[s] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
                                                     8'($urandom_range(0, 23));
            case ($urandom_range(0, 5))
                0: wts[s] = '0;
                1: wts[s] = WEIGHT_FULL;
                2: wts[s] = 16'd1;
                3: wts[s] = tie_weight;
                default: wts[s] = 16'($urandom);
            endcase
        end
        v = make_vertex($urandom_range(0, 39) == 0, bones[0], bones[1], bones[2],
                        bones[3], wts[0], wts[1], wts[2], wts[3]);
        return v;
    endfunction

    // Offers one item and, once taken, records what it must produce.
    task automatic send_vertex(input t_in_item v, input logic typed,
                               input t_out_item typed_result);
        t_out_item predicted;
        @(negedge i_clk);
        start  = 1'b1;
        i_item = v;
        do @(posedge i_clk); while (busy);
        predicted = compact_vertex(v);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // Stops sending and waits until every outstanding result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        slot_count_cfg = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Result checker: each strobed item against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("primary_bone", int'(oldest_result.primary_bone),
                            int'(o_result.primary_bone));
                check_field("dense_id_1", int'(oldest_result.dense_id_1),
                            int'(o_result.dense_id_1));
                check_field("dense_id_2", int'(oldest_result.dense_id_2),
                            int'(o_result.dense_id_2));
                check_field("dense_id_3", int'(oldest_result.dense_id_3),
                            int'(o_result.dense_id_3));
                check_field("new_mask", int'(oldest_result.new_mask),
                            int'(o_result.new_mask));
                check_field("ids_used", int'(oldest_result.ids_used),
                            int'(o_result.ids_used));
                check_field("overflow", int'(oldest_result.overflow),
                            int'(o_result.overflow));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int burst_left;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        clear_bone_store();
        slot_count_cfg = CFG_RESET;

        // All weights zero: slot 0 supplies its raw index, nothing assigned.
        add_row(0, 0, make_vertex(0, 10, 20, 30, 40, 0, 0, 0, 0),
                1, make_result(10, 20, 30, 40, 4'h0, 0, 0));
        // Index and weight extremes; tie at full weight goes to slot 0.
        add_row(0, 0, make_vertex(0, 255, 0, 128, 1, WEIGHT_FULL, 1, 16'h8000,
                                  WEIGHT_FULL),
                1, make_result(0, 1, 2, 3, 4'hF, 4, 0));
        // Same bones again: no new IDs, heaviest is the last slot.
        add_row(0, 0, make_vertex(0, 255, 0, 128, 1, 1, 2, 3, 4), 0, '0);
        // One bone in several slots gets a single ID.
        add_row(0, 0, make_vertex(0, 7, 7, 7, 7, 1, 1, 0, 1), 0, '0);
        // Clear ahead of the vertex; only the last slot carries weight.
        add_row(0, 0, make_vertex(1, 9, 8, 7, 6, 0, 0, 0, 3), 0, '0);
        // One slot examined, and that slot weightless.
        add_row(1, 3'd1, make_vertex(0, 50, 51, 52, 53, 0, 9, 9, 9), 0, '0);
        add_row(0, 0, make_vertex(0, 50, 51, 52, 53, 2, 9, 9, 9), 0, '0);
        // A slot count of zero behaves as one.
        add_row(1, 3'd0, make_vertex(0, 60, 61, 62, 63, 1, 1, 1, 1), 0, '0);
        // Counts above four are held at four.
        add_row(1, 3'd7, make_vertex(0, 60, 61, 62, 63, 1, 2, 3, 4), 0, '0);
        add_row(1, 3'd2, make_vertex(0, 70, 71, 72, 73, 1, 1, 1, 1), 0, '0);
        add_row(1, 3'd3, make_vertex(0, 70, 74, 75, 76, 0, 0, WEIGHT_FULL, 1), 0, '0);
        // Assign sixty dense IDs four at a time from a fresh store.
        for (int k = 0; k < 15; k++) begin
            add_row(k == 0, 3'd4,
                    make_vertex(k == 0, 8'(100 + 4 * k), 8'(101 + 4 * k),
                                8'(102 + 4 * k), 8'(103 + 4 * k), 1, 1, 1, 1),
                    0, '0);
        end
        add_row(0, 0, make_vertex(0, 170, 171, 100, 101, 1, 1, 1, 1), 0, '0);
        // Runs out of IDs on slot 2; the first two assignments stand.
        add_row(0, 0, make_vertex(0, 210, 211, 212, 213, WEIGHT_FULL, WEIGHT_FULL,
                                  WEIGHT_FULL, WEIGHT_FULL),
                1, make_result(0, 0, 0, 0, 4'h3, 64, 1));
        // The error holds even for bones that are already mapped.
        add_row(0, 0, make_vertex(0, 100, 101, 102, 103, 1, 1, 1, 1),
                1, make_result(0, 0, 0, 0, 4'h0, 64, 1));
        add_row(0, 0, make_vertex(1, 5, 6, 7, 8, 1, 0, 0, 0), 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, with random hold-offs between items.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].cfg_write) begin
                drain_results();
                write_slot_count(directed_rows[r].cfg_value);
            end
            send_vertex(directed_rows[r].stim, directed_rows[r].typed,
                        directed_rows[r].result);
            if ($urandom_range(0, 1) == 0) hold_off($urandom_range(1, 6));
        end

        // Random part: bursts of items with gaps, slot count changes between
        // phases once every result is back.
        burst_left = $urandom_range(1, 24);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % CFG_EVERY == 0) begin
                drain_results();
                write_slot_count(CFG_W'($urandom_range(0, 7)));
            end
            send_vertex(random_vertex(), 1'b0, '0);
            burst_left--;
            if (burst_left == 0) begin
                hold_off($urandom_range(1, 10));
                burst_left = $urandom_range(1, 24);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
